### rtl/sncs_pkg.sv
// ---------------------------------------------------------------------------
// sncs_pkg
// shared types, codes and helpers of the spi nor flash command sequencer
// ---------------------------------------------------------------------------
package sncs_pkg;

  localparam int CHUNK_BYTES  = 256;
  localparam int ID_BYTES     = 4;
  localparam int ADDRESS_BITS = 24;
  localparam int GROUP_SIZE   = 4;

  localparam logic [23:0] ADDR_MASK = 24'((25'd1 << ADDRESS_BITS) - 25'd1);

  localparam logic [7:0] OPC_READ    = 8'h03;
  localparam logic [7:0] OPC_PROGRAM = 8'h02;
  localparam logic [7:0] OPC_WREN    = 8'h06;
  localparam logic [7:0] OPC_STATUS  = 8'h05;
  localparam logic [7:0] OPC_ERASE   = 8'hd8;
  localparam logic [7:0] OPC_RES     = 8'hab;
  localparam logic [7:0] OPC_JEDEC   = 8'h9f;
  localparam logic [7:0] DUMMY_BYTE  = 8'hff;

  localparam logic [23:0] ID_SMALL_A = 24'h20ba18;
  localparam logic [23:0] ID_SMALL_B = 24'h012018;
  localparam logic [23:0] ID_LARGE   = 24'h202018;

  typedef enum logic [1:0] {
    CMD_HOST = 2'd0,
    CMD_DATA = 2'd1,
    CMD_RECV = 2'd2,
    CMD_NONE = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_PROGRAM = 2'd1,
    OP_ERASE   = 2'd2,
    OP_READID  = 2'd3
  } operation_t;

  typedef enum logic [2:0] {
    ACT_SELECT   = 3'd0,
    ACT_SEND     = 3'd1,
    ACT_DESELECT = 3'd2,
    ACT_READ     = 3'd3,
    ACT_WANT     = 3'd4,
    ACT_DONE     = 3'd5,
    ACT_UNKNOWN  = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ADDR,
    PH_RDDATA,
    PH_WANT,
    PH_PDATA,
    PH_WREN,
    PH_STCMD,
    PH_STDATA,
    PH_ID1,
    PH_ID2
  } phase_t;

  // results caused by one request, oldest in slot 0
  typedef struct packed {
    logic [2:0]                  count;
    logic [GROUP_SIZE-1:0][2:0]  act;
    logic [GROUP_SIZE-1:0][7:0]  bytes;
  } group_t;

  function automatic group_t put(group_t g, action_t a, logic [7:0] b);
    group_t r;
    r = g;
    r.act[g.count[1:0]]   = a;
    r.bytes[g.count[1:0]] = b;
    r.count               = g.count + 3'd1;
    return r;
  endfunction

endpackage

### rtl/sncs_if.sv
// ---------------------------------------------------------------------------
// sncs request and result channels
// valid/ready channels carrying requests in and spi steps out
// ---------------------------------------------------------------------------
interface sncs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  operation;
  logic [23:0] address;
  logic [24:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, command, operation, address, length, data_byte,
                  input ready);
  modport sink (input valid, command, operation, address, length, data_byte,
                output ready);
endinterface

interface sncs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  out_byte;
  logic        last;

  modport source (output valid, action, out_byte, last, input ready);
  modport sink (input valid, action, out_byte, last, output ready);
endinterface

### rtl/sncs_front.sv
// ---------------------------------------------------------------------------
// sncs_front
// takes requests, steps the sequencer state and builds each result group
// ---------------------------------------------------------------------------
module sncs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [1:0]          operation,
  input  logic [23:0]         address,
  input  logic [24:0]         length,
  input  logic [7:0]          data_byte,
  input  logic                q_full,
  output logic                push,
  output sncs_pkg::group_t    grp
);

  sncs_pkg::phase_t     phase, phase_next;
  sncs_pkg::operation_t current_operation, current_operation_next;
  logic [23:0]          running_address, running_address_next;
  logic [24:0]          bytes_left, bytes_left_next;
  logic [8:0]           chunk_count, chunk_count_next;
  logic [2:0]           byte_index, byte_index_next;
  logic [23:0]          id_bytes, id_bytes_next;
  logic                 sector_is_large, sector_is_large_next;
  logic                 accept;
  logic [24:0]          sector;
  logic [24:0]          left_dec;
  logic [8:0]           chunk_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (grp.count != 3'd0);

  always_comb begin
    phase_next             = phase;
    current_operation_next = current_operation;
    running_address_next   = running_address;
    bytes_left_next        = bytes_left;
    chunk_count_next       = chunk_count;
    byte_index_next        = byte_index;
    id_bytes_next          = id_bytes;
    sector_is_large_next   = sector_is_large;
    grp                    = '0;
    sector    = sector_is_large ? 25'h40000 : 25'h10000;
    left_dec  = (bytes_left != 25'd0) ? bytes_left - 25'd1 : 25'd0;
    chunk_dec = (chunk_count != 9'd0) ? chunk_count - 9'd1 : 9'd0;

    case (sncs_pkg::command_t'(command))
      sncs_pkg::CMD_HOST: begin
        if (phase == sncs_pkg::PH_IDLE) begin
          current_operation_next = sncs_pkg::operation_t'(operation);
          running_address_next   = address & sncs_pkg::ADDR_MASK;
          bytes_left_next        = length;
          byte_index_next        = 3'd0;
          if (operation != sncs_pkg::OP_READID && length == 25'd0) begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_DONE, 8'h00);
          end else if (operation == sncs_pkg::OP_READ) begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_READ);
            phase_next = sncs_pkg::PH_ADDR;
          end else if (operation == sncs_pkg::OP_PROGRAM) begin
            chunk_count_next = (length > 25'(sncs_pkg::CHUNK_BYTES)) ?
                               9'(sncs_pkg::CHUNK_BYTES) : length[8:0];
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_WREN);
            phase_next = sncs_pkg::PH_WREN;
          end else begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_RES);
            phase_next = sncs_pkg::PH_ID1;
          end
        end
      end
      sncs_pkg::CMD_DATA: begin
        if (phase == sncs_pkg::PH_WANT) begin
          grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, data_byte);
          phase_next = sncs_pkg::PH_PDATA;
        end
      end
      sncs_pkg::CMD_RECV: begin
        case (phase)
          sncs_pkg::PH_ADDR: begin
            if (byte_index < 3'd3) begin
              case (byte_index[1:0])
                2'd0: grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND,
                                          running_address[23:16]);
                2'd1: grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND,
                                          running_address[15:8]);
                default: grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND,
                                             running_address[7:0]);
              endcase
              byte_index_next = byte_index + 3'd1;
            end else if (current_operation == sncs_pkg::OP_READ) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::DUMMY_BYTE);
              phase_next = sncs_pkg::PH_RDDATA;
            end else if (current_operation == sncs_pkg::OP_PROGRAM) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_WANT, 8'h00);
              phase_next = sncs_pkg::PH_WANT;
            end else begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
              bytes_left_next = (bytes_left > sector) ? bytes_left - sector : 25'd0;
              running_address_next = (running_address + sector[23:0]) &
                                     sncs_pkg::ADDR_MASK;
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_STATUS);
              phase_next = sncs_pkg::PH_STCMD;
            end
          end
          sncs_pkg::PH_RDDATA: begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_READ, data_byte);
            bytes_left_next = left_dec;
            if (left_dec != 25'd0) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::DUMMY_BYTE);
            end else begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DONE, 8'h00);
              phase_next = sncs_pkg::PH_IDLE;
            end
          end
          sncs_pkg::PH_PDATA: begin
            chunk_count_next     = chunk_dec;
            bytes_left_next      = left_dec;
            running_address_next = (running_address + 24'd1) & sncs_pkg::ADDR_MASK;
            if (chunk_dec != 9'd0) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_WANT, 8'h00);
              phase_next = sncs_pkg::PH_WANT;
            end else begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_STATUS);
              phase_next = sncs_pkg::PH_STCMD;
            end
          end
          sncs_pkg::PH_WREN: begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND,
                                (current_operation == sncs_pkg::OP_PROGRAM) ?
                                sncs_pkg::OPC_PROGRAM : sncs_pkg::OPC_ERASE);
            byte_index_next = 3'd0;
            phase_next      = sncs_pkg::PH_ADDR;
          end
          sncs_pkg::PH_STCMD: begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::DUMMY_BYTE);
            phase_next = sncs_pkg::PH_STDATA;
          end
          sncs_pkg::PH_STDATA: begin
            grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
            if (data_byte[0]) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_STATUS);
              phase_next = sncs_pkg::PH_STCMD;
            end else if (bytes_left != 25'd0) begin
              if (current_operation == sncs_pkg::OP_PROGRAM) begin
                chunk_count_next = (bytes_left > 25'(sncs_pkg::CHUNK_BYTES)) ?
                                   9'(sncs_pkg::CHUNK_BYTES) : bytes_left[8:0];
              end
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_WREN);
              phase_next = sncs_pkg::PH_WREN;
            end else begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DONE, 8'h00);
              phase_next = sncs_pkg::PH_IDLE;
            end
          end
          sncs_pkg::PH_ID1: begin
            if (current_operation == sncs_pkg::OP_READID && byte_index != 3'd0) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_READ, data_byte);
            end
            if (byte_index < 3'(sncs_pkg::ID_BYTES)) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::DUMMY_BYTE);
              byte_index_next = byte_index + 3'd1;
            end else begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_JEDEC);
              byte_index_next = 3'd0;
              id_bytes_next   = 24'd0;
              phase_next      = sncs_pkg::PH_ID2;
            end
          end
          sncs_pkg::PH_ID2: begin
            if (byte_index >= 3'd1 && byte_index <= 3'd3) begin
              id_bytes_next = {id_bytes[15:0], data_byte};
            end
            if (current_operation == sncs_pkg::OP_READID && byte_index != 3'd0) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_READ, data_byte);
            end
            if (byte_index < 3'(sncs_pkg::ID_BYTES)) begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::DUMMY_BYTE);
              byte_index_next = byte_index + 3'd1;
            end else begin
              grp = sncs_pkg::put(grp, sncs_pkg::ACT_DESELECT, 8'h00);
              if (current_operation == sncs_pkg::OP_READID) begin
                grp = sncs_pkg::put(grp, sncs_pkg::ACT_DONE, 8'h00);
                phase_next = sncs_pkg::PH_IDLE;
              end else if (id_bytes == sncs_pkg::ID_SMALL_A ||
                           id_bytes == sncs_pkg::ID_SMALL_B ||
                           id_bytes == sncs_pkg::ID_LARGE) begin
                sector_is_large_next = (id_bytes == sncs_pkg::ID_LARGE);
                if (current_operation == sncs_pkg::OP_PROGRAM) begin
                  chunk_count_next = (bytes_left > 25'(sncs_pkg::CHUNK_BYTES)) ?
                                     9'(sncs_pkg::CHUNK_BYTES) : bytes_left[8:0];
                end
                grp = sncs_pkg::put(grp, sncs_pkg::ACT_SELECT, 8'h00);
                grp = sncs_pkg::put(grp, sncs_pkg::ACT_SEND, sncs_pkg::OPC_WREN);
                phase_next = sncs_pkg::PH_WREN;
              end else begin
                grp = sncs_pkg::put(grp, sncs_pkg::ACT_UNKNOWN, 8'h00);
                phase_next = sncs_pkg::PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= sncs_pkg::PH_IDLE;
      current_operation <= sncs_pkg::OP_READ;
      running_address   <= '0;
      bytes_left        <= '0;
      chunk_count       <= '0;
      byte_index        <= '0;
      id_bytes          <= '0;
      sector_is_large   <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      current_operation <= current_operation_next;
      running_address   <= running_address_next;
      bytes_left        <= bytes_left_next;
      chunk_count       <= chunk_count_next;
      byte_index        <= byte_index_next;
      id_bytes          <= id_bytes_next;
      sector_is_large   <= sector_is_large_next;
    end
  end

endmodule

### rtl/sncs_queue.sv
// ---------------------------------------------------------------------------
// sncs_queue
// two-entry queue of result groups between front and back
// ---------------------------------------------------------------------------
module sncs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sncs_pkg::group_t wr_grp,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output sncs_pkg::group_t rd_grp
);

  sncs_pkg::group_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full   = (fill == 2'd2);
  assign empty  = (fill == 2'd0);
  assign rd_grp = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/sncs_back.sv
// ---------------------------------------------------------------------------
// sncs_back
// walks through the queued group and hands out one result a cycle while out_ready is high
// ---------------------------------------------------------------------------
module sncs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  sncs_pkg::group_t grp,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       action,
  output logic [7:0]       out_byte,
  output logic             last
);

  logic [1:0] slot;
  logic       take;

  assign out_valid = !empty;
  assign action    = grp.act[slot];
  assign out_byte  = grp.bytes[slot];
  assign last      = ({1'b0, slot} == grp.count - 3'd1);
  assign take      = out_valid && out_ready;
  assign pop       = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 2'd0;
    end else if (take) begin
      slot <= last ? 2'd0 : slot + 2'd1;
    end
  end

endmodule

### rtl/spi_nor_flash_command_sequencer_top.sv
// ---------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_top
// turns flash requests into select, send, deselect and host result steps
// ---------------------------------------------------------------------------
// usage
//   req carries host requests (read, program, erase, read id), program data
//   bytes and bytes received from the spi shifter outside this block
//   rsp carries the resulting steps, one per transfer; last marks the final
//   step caused by one request
// flow
//   a request is taken while req ready is high; its steps (one to four) are
//   queued and appear one per cycle while rsp ready is high; req ready drops
//   only when the two-entry group queue is full
// reset
//   rst, synchronous: sequencer returns to idle, queue and step index clear
// stalls
//   when rsp ready is low the current step holds; the front keeps taking
//   requests until both queue entries are occupied
// ---------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  sncs_req_if.sink   req,
  sncs_rsp_if.source rsp
);

  // group from the front, waiting to be serialised
  sncs_pkg::group_t wr_grp;
  sncs_pkg::group_t rd_grp;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  // front: owns the sequencer state and builds one group per request
  sncs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .command   (req.command),
    .operation (req.operation),
    .address   (req.address),
    .length    (req.length),
    .data_byte (req.data_byte),
    .q_full    (full),
    .push      (push),
    .grp       (wr_grp)
  );

  // queue decouples request intake from result delivery
  sncs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_grp (wr_grp),
    .pop    (pop),
    .full   (full),
    .empty  (empty),
    .rd_grp (rd_grp)
  );

  // back: one step per accepted transfer
  sncs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .grp       (rd_grp),
    .pop       (pop),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .action    (rsp.action),
    .out_byte  (rsp.out_byte),
    .last      (rsp.last)
  );

endmodule

### tb/sv/sncs_checker.sv
// ---------------------------------------------------------------------------
// sncs_checker
// watches both channels, predicts the spi steps of every request and
// compares each result with the oldest step still due
// ---------------------------------------------------------------------------
module sncs_checker
  import sncs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sncs_req_if        req,
  sncs_rsp_if        rsp,
  output int         errors,
  output int         pending
);

  typedef struct {
    action_t    act;
    logic [7:0] b;
    logic       last;
  } step_t;

  step_t steps_due[$];
  step_t fresh[$];

  phase_t      ph;
  operation_t  cur_op;
  logic [23:0] run_addr;
  logic [24:0] left;
  logic [8:0]  chunk;
  logic [2:0]  bidx;
  logic [23:0] idw;
  logic        big_sect;

  function automatic void note(action_t a, logic [7:0] b);
    fresh.push_back('{a, b, 1'b0});
  endfunction

  function automatic void start_wren();
    if (cur_op == OP_PROGRAM)
      chunk = (left > 25'd256) ? 9'd256 : left[8:0];
    note(ACT_SELECT, 8'h00);
    note(ACT_SEND, OPC_WREN);
    ph = PH_WREN;
  endfunction

  function automatic void start_status();
    note(ACT_SELECT, 8'h00);
    note(ACT_SEND, OPC_STATUS);
    ph = PH_STCMD;
  endfunction

  function automatic void take_request(operation_t op, logic [23:0] a, logic [24:0] l);
    cur_op   = op;
    run_addr = a & ADDR_MASK;
    left     = l;
    bidx     = 3'd0;
    if (op != OP_READID && l == 25'd0) begin
      note(ACT_DONE, 8'h00);
    end else if (op == OP_PROGRAM) begin
      start_wren();
    end else if (op == OP_READ) begin
      note(ACT_SELECT, 8'h00);
      note(ACT_SEND, OPC_READ);
      ph = PH_ADDR;
    end else begin
      note(ACT_SELECT, 8'h00);
      note(ACT_SEND, OPC_RES);
      ph = PH_ID1;
    end
  endfunction

  function automatic void take_reply(logic [7:0] d);
    logic [24:0] sector;
    case (ph)
      PH_ADDR: begin
        if (bidx < 3'd3) begin
          note(ACT_SEND, 8'(run_addr >> (8 * (2 - bidx))));
          bidx = bidx + 3'd1;
        end else if (cur_op == OP_READ) begin
          note(ACT_SEND, DUMMY_BYTE);
          ph = PH_RDDATA;
        end else if (cur_op == OP_PROGRAM) begin
          note(ACT_WANT, 8'h00);
          ph = PH_WANT;
        end else begin
          note(ACT_DESELECT, 8'h00);
          sector   = big_sect ? 25'h40000 : 25'h10000;
          left     = (left > sector) ? left - sector : 25'd0;
          run_addr = (run_addr + sector[23:0]) & ADDR_MASK;
          start_status();
        end
      end
      PH_RDDATA: begin
        note(ACT_READ, d);
        if (left > 0) left = left - 25'd1;
        if (left > 0) begin
          note(ACT_SEND, DUMMY_BYTE);
        end else begin
          note(ACT_DESELECT, 8'h00);
          note(ACT_DONE, 8'h00);
          ph = PH_IDLE;
        end
      end
      PH_PDATA: begin
        if (chunk > 0) chunk = chunk - 9'd1;
        if (left > 0) left = left - 25'd1;
        run_addr = (run_addr + 24'd1) & ADDR_MASK;
        if (chunk > 0) begin
          note(ACT_WANT, 8'h00);
          ph = PH_WANT;
        end else begin
          note(ACT_DESELECT, 8'h00);
          start_status();
        end
      end
      PH_WREN: begin
        note(ACT_DESELECT, 8'h00);
        note(ACT_SELECT, 8'h00);
        note(ACT_SEND, (cur_op == OP_PROGRAM) ? OPC_PROGRAM : OPC_ERASE);
        bidx = 3'd0;
        ph   = PH_ADDR;
      end
      PH_STCMD: begin
        note(ACT_SEND, DUMMY_BYTE);
        ph = PH_STDATA;
      end
      PH_STDATA: begin
        note(ACT_DESELECT, 8'h00);
        if (d[0]) begin
          start_status();
        end else if (left > 0) begin
          start_wren();
        end else begin
          note(ACT_DONE, 8'h00);
          ph = PH_IDLE;
        end
      end
      PH_ID1: begin
        if (cur_op == OP_READID && bidx >= 3'd1) note(ACT_READ, d);
        if (bidx < 3'(ID_BYTES)) begin
          note(ACT_SEND, DUMMY_BYTE);
          bidx = bidx + 3'd1;
        end else begin
          note(ACT_DESELECT, 8'h00);
          note(ACT_SELECT, 8'h00);
          note(ACT_SEND, OPC_JEDEC);
          bidx = 3'd0;
          idw  = 24'd0;
          ph   = PH_ID2;
        end
      end
      PH_ID2: begin
        if (bidx >= 3'd1 && bidx <= 3'd3) idw = {idw[15:0], d};
        if (cur_op == OP_READID && bidx >= 3'd1) note(ACT_READ, d);
        if (bidx < 3'(ID_BYTES)) begin
          note(ACT_SEND, DUMMY_BYTE);
          bidx = bidx + 3'd1;
        end else begin
          note(ACT_DESELECT, 8'h00);
          if (cur_op == OP_READID) begin
            note(ACT_DONE, 8'h00);
            ph = PH_IDLE;
          end else if (idw == ID_SMALL_A || idw == ID_SMALL_B) begin
            big_sect = 1'b0;
            start_wren();
          end else if (idw == ID_LARGE) begin
            big_sect = 1'b1;
            start_wren();
          end else begin
            note(ACT_UNKNOWN, 8'h00);
            ph = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    step_t s;
    if (rst) begin
      ph       = PH_IDLE;
      cur_op   = OP_READ;
      run_addr = '0;
      left     = '0;
      chunk    = '0;
      bidx     = '0;
      idw      = '0;
      big_sect = 1'b0;
      steps_due.delete();
      errors   = 0;
    end else begin
      // results first: they always belong to earlier requests
      if (rsp.valid && rsp.ready) begin
        if (steps_due.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected result: action %0d byte %h last %b",
                     rsp.action, rsp.out_byte, rsp.last);
        end else begin
          s = steps_due.pop_front();
          if (rsp.action !== s.act || rsp.out_byte !== s.b || rsp.last !== s.last) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: expected action %0d byte %h last %b, got %0d %h %b",
                       s.act, s.b, s.last, rsp.action, rsp.out_byte, rsp.last);
          end
        end
      end
      if (req.valid && req.ready) begin
        fresh.delete();
        case (command_t'(req.command))
          CMD_HOST: if (ph == PH_IDLE)
            take_request(operation_t'(req.operation), req.address, req.length);
          CMD_DATA: if (ph == PH_WANT) begin
            note(ACT_SEND, req.data_byte);
            ph = PH_PDATA;
          end
          CMD_RECV: take_reply(req.data_byte);
          default: ;
        endcase
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) steps_due.push_back(fresh[i]);
      end
    end
    pending = steps_due.size();
  end

endmodule

### tb/sv/tb_spi_nor_flash_command_sequencer_top.sv
// ---------------------------------------------------------------------------
// tb_spi_nor_flash_command_sequencer_top
// plays host and spi shifter around the sequencer: issues read, program,
// erase and read id requests, answers every byte sent and every data want,
// mixes in ignored noise, and lets the checker judge each result
// ---------------------------------------------------------------------------
module tb_spi_nor_flash_command_sequencer_top;
  import sncs_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;

  sncs_req_if req_ch();
  sncs_rsp_if rsp_ch();

  spi_nor_flash_command_sequencer_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sncs_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #6 clk = ~clk;

  // calm stretches switch off all idling on both sides
  logic calm = 1'b0;

  // what the block has asked for so far, as seen on the result channel
  int          sends_seen = 0;
  int          wants_seen = 0;
  int          ends_seen  = 0;
  int          lasts_seen = 0;
  logic [7:0]  prev_sent  = 8'h00;
  logic        status_next = 1'b0;   // next reply answers a status poll
  int          id_pos     = 7;       // sends since the jedec id opcode

  // what the host side has given so far
  int          recvs_sent = 0;
  int          datas_sent = 0;
  int          ops_started = 0;
  int          lasts_due  = 0;
  int          items_sent = 0;
  int          busy_run   = 0;
  logic [23:0] chip_id;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_ch.last) lasts_seen <= lasts_seen + 1;
      case (action_t'(rsp_ch.action))
        ACT_SEND: begin
          sends_seen  <= sends_seen + 1;
          prev_sent   <= rsp_ch.out_byte;
          status_next <= (rsp_ch.out_byte == DUMMY_BYTE && prev_sent == OPC_STATUS);
          if (rsp_ch.out_byte == OPC_JEDEC) id_pos <= 0;
          else if (id_pos < 7) id_pos <= id_pos + 1;
        end
        ACT_WANT: wants_seen <= wants_seen + 1;
        ACT_DONE, ACT_UNKNOWN: ends_seen <= ends_seen + 1;
        default: ;
      endcase
    end
  end

  initial begin
    forever begin
      repeat (250) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // result side: random stall before each result
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // one request; when it causes results, hold off until the last has come
  task automatic send_item(command_t c, operation_t o, logic [23:0] a,
                           logic [24:0] l, logic [7:0] d, bit causes);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.command   <= c;
    req_ch.operation <= o;
    req_ch.address   <= a;
    req_ch.length    <= l;
    req_ch.data_byte <= d;
    do @(posedge clk); while (!req_ch.ready);
    gap = calm ? 0 : $urandom_range(0, 6);
    if (causes || gap > 0) req_ch.valid <= 1'b0;
    if (causes) begin
      lasts_due = lasts_due + 1;
      while (lasts_seen != lasts_due) @(posedge clk);
    end
    repeat (gap) @(posedge clk);
  endtask

  // a request the block must ignore in its present phase
  task automatic send_noise();
    command_t c;
    c = command_t'($urandom_range(0, 3));
    if (c == CMD_DATA && wants_seen != datas_sent) c = CMD_NONE;
    if (c == CMD_RECV && sends_seen != recvs_sent) c = CMD_NONE;
    if (c == CMD_HOST && ops_started == ends_seen) c = CMD_NONE;
    send_item(c, operation_t'($urandom_range(0, 3)), 24'($urandom),
              25'($urandom), 8'($urandom), 1'b0);
  endtask

  // byte the spi shifter hands back for the send awaiting an answer
  function automatic logic [7:0] spi_reply();
    logic [7:0] d;
    d = 8'($urandom);
    if (id_pos >= 1 && id_pos <= 3) begin
      d = chip_id[8 * (3 - id_pos) +: 8];
    end else if (status_next) begin
      // busy now and then, but never for long
      d[0] = (busy_run < 3) && ($urandom_range(0, 2) == 0);
      busy_run = d[0] ? busy_run + 1 : 0;
    end
    return d;
  endfunction

  // a whole operation from host request to done or unknown chip
  task automatic run_op(operation_t op, logic [23:0] a, logic [24:0] l,
                        logic [23:0] chip);
    chip_id = chip;
    ops_started = ops_started + 1;
    items_sent  = items_sent + 1;
    send_item(CMD_HOST, op, a, l, 8'($urandom), 1'b1);
    while (ops_started != ends_seen) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      if (sends_seen != recvs_sent) begin
        recvs_sent = recvs_sent + 1;
        items_sent = items_sent + 1;
        send_item(CMD_RECV, operation_t'($urandom_range(0, 3)), 24'($urandom),
                  25'($urandom), spi_reply(), 1'b1);
      end else if (wants_seen != datas_sent) begin
        datas_sent = datas_sent + 1;
        items_sent = items_sent + 1;
        send_item(CMD_DATA, operation_t'($urandom_range(0, 3)), 24'($urandom),
                  25'($urandom), 8'($urandom), 1'b1);
      end else begin
        @(posedge clk);
      end
    end
  endtask

  function automatic logic [23:0] pick_chip();
    case ($urandom_range(0, 4))
      0: return ID_SMALL_A;
      1: return ID_SMALL_B;
      2, 3: return ID_LARGE;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_address();
    case ($urandom_range(0, 3))
      0: return 24'hffffff - 24'($urandom_range(0, 8));
      1: return 24'($urandom_range(0, 8));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    operation_t  op;
    logic [24:0] l;
    int          guard;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.command   <= CMD_NONE;
    req_ch.operation <= OP_READ;
    req_ch.address   <= '0;
    req_ch.length    <= '0;
    req_ch.data_byte <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero lengths, every chip id and address wrap
    run_op(OP_READ, 24'h000000, 25'd1, ID_LARGE);
    run_op(OP_READ, 24'hffffff, 25'd3, ID_LARGE);
    run_op(OP_READ, 24'h123456, 25'd0, ID_LARGE);
    run_op(OP_PROGRAM, 24'hffffff, 25'd0, ID_LARGE);
    run_op(OP_ERASE, 24'h000000, 25'd0, ID_LARGE);
    run_op(OP_READID, 24'hffffff, 25'h1000000, ID_LARGE);
    run_op(OP_PROGRAM, 24'hfffffe, 25'd4, ID_LARGE);
    run_op(OP_ERASE, 24'hff0000, 25'h20000, ID_SMALL_A);
    run_op(OP_ERASE, 24'h000000, 25'd1, ID_SMALL_B);
    run_op(OP_ERASE, 24'hfc0000, 25'h40001, ID_LARGE);
    run_op(OP_ERASE, 24'h000000, 25'd5, 24'h123456);

    // random operations, most of them well formed, short lengths
    while (items_sent < 170) begin
      op = operation_t'($urandom_range(0, 3));
      case (op)
        OP_READ:    l = 25'($urandom_range(1, 12));
        OP_PROGRAM: l = 25'($urandom_range(1, 24));
        OP_ERASE:   l = 25'($urandom_range(1, 25'h30000));
        default:    l = 25'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) l = '0;
      run_op(op, pick_address(), l, pick_chip());
    end

    req_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard = guard + 1;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // generous limit on the whole run
  initial begin
    #(12 * 2000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### spi_nor_flash_command_sequencer_top.f
rtl/sncs_pkg.sv
rtl/sncs_if.sv
rtl/sncs_front.sv
rtl/sncs_queue.sv
rtl/sncs_back.sv
rtl/spi_nor_flash_command_sequencer_top.sv
tb/sv/sncs_checker.sv
tb/sv/tb_spi_nor_flash_command_sequencer_top.sv
